// ===== hdl/sha1_hash_engine_assert.svh =====
// Assertion macros for the SHA-1 engine RTL.
`ifndef SHA1_HASH_ENGINE_ASSERT_SVH
`define SHA1_HASH_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SHA1_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SHA1_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sha1_pkg.sv =====
// Shared widths and SHA-1 constants for the hash engine.
`timescale 1ns / 1ps

package sha1_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned NUM_CHAIN = 5;
  localparam int unsigned WIN_DEPTH = 16;
  localparam int unsigned FILL_W    = 6;
  localparam int unsigned ROUND_W   = 7;
  localparam int unsigned LEN_W     = 64;

  localparam logic [IDX_W-1:0]   LAST_IDX   = 3'd4;
  localparam logic [ROUND_W-1:0] LAST_ROUND = 7'd79;
  localparam logic [FILL_W-1:0]  LAST_FILL  = 6'd63;
  localparam logic [FILL_W-1:0]  LEN_FILL   = 6'd56;
  localparam logic [BYTE_W-1:0]  PAD_BYTE   = 8'h80;

  localparam logic [WORD_W-1:0] H_INIT [NUM_CHAIN] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [WORD_W-1:0] K_0 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K_1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K_2 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K_3 = 32'hCA62C1D6;

endpackage

// ===== hdl/sha1_if.sv =====
// Valid/ready channel interfaces for message bytes and digest words.
`timescale 1ns / 1ps

interface sha1_in_if import sha1_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              byte_present;
  logic              end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha1_out_if import sha1_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] digest_word;
  logic [IDX_W-1:0]  word_index;
  logic              last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== hdl/sha1_hash_engine.sv =====
// SHA-1 engine top level: byte intake, padding, round sequencer and digest output.
// Usage:
//   in_ch carries one message byte per item (byte_present) and an end mark
//   (end_of_message). A mark with no byte ends the message; an item with
//   neither is a no-op. out_ch delivers the digest as five 32-bit words,
//   word_index 0 (h0) first, last_word set on word 4.
// Flow:
//   A byte item is taken while the engine is idle. Each 64th byte starts the
//   compression of the block: 80 rounds of the single round unit, then a fold
//   of the result into the chaining words; in_ch.ready is low meanwhile.
//   After the end mark, padding and length bytes are written one per cycle
//   (up to 64, or up to 72 when the length spills into an extra block),
//   each full block is compressed the same way, then one word per cycle is
//   loaded into the output register while out_ch.ready allows it.
// Reset: rst_n (synchronous, active low) restores the initial chaining words
//   and clears byte and bit counts and the output valid flag.
// Stall: a low out_ch.ready holds the current word; the engine waits before
//   loading the next one and takes the next message once the digest is queued.
`timescale 1ns / 1ps

module sha1_hash_engine import sha1_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sha1_in_if.sink     in_ch,
  sha1_out_if.source  out_ch
);

  `include "sha1_hash_engine_assert.svh"

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_FOLD  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [FILL_W-1:0]   fill_r;
  logic [23:0]         acc_r;
  logic [WORD_W-1:0]   win_r   [WIN_DEPTH];
  logic [WORD_W-1:0]   work_r  [NUM_CHAIN];
  logic [WORD_W-1:0]   chain_r [NUM_CHAIN];
  logic [ROUND_W-1:0]  round_r;
  logic [LEN_W-1:0]    bit_count_r;
  logic                pad_active_r;
  logic                pad_first_r;
  logic                extra_r;
  logic                final_r;
  logic [IDX_W-1:0]    word_sel_r;
  logic                out_valid_r;
  logic [WORD_W-1:0]   out_word_r;
  logic [IDX_W-1:0]    out_idx_r;
  logic                out_last_r;

  logic                in_fire;
  logic                byte_we;
  logic [BYTE_W-1:0]   byte_val;
  logic                len_phase;
  logic [BYTE_W-1:0]   len_byte;
  logic [WORD_W-1:0]   f_val;
  logic [WORD_W-1:0]   k_val;
  logic [WORD_W-1:0]   round_sum;
  logic [WORD_W-1:0]   sched_x;
  logic [WORD_W-1:0]   sched_new;
  logic                out_load;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.digest_word = out_word_r;
  assign out_ch.word_index  = out_idx_r;
  assign out_ch.last_word   = out_last_r;

  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);

  // Length bytes go out most significant first at fill 56..63.
  assign len_phase = !pad_first_r && !extra_r && (fill_r >= LEN_FILL);
  assign len_byte  = BYTE_W'(bit_count_r >> {~fill_r[2:0], 3'b000});

  always_comb begin
    byte_we  = 1'b0;
    byte_val = '0;
    unique case (state_r)
      ST_IDLE: begin
        byte_we  = in_fire && in_ch.byte_present;
        byte_val = in_ch.data_byte;
      end
      ST_PAD: begin
        byte_we = 1'b1;
        if (pad_first_r) begin
          byte_val = PAD_BYTE;
        end else if (len_phase) begin
          byte_val = len_byte;
        end else begin
          byte_val = '0;
        end
      end
      default: begin
        byte_we  = 1'b0;
        byte_val = '0;
      end
    endcase
  end

  // Round unit: one SHA-1 round per cycle.
  always_comb begin
    if (round_r < 7'd20) begin
      f_val = (work_r[1] & work_r[2]) | (~work_r[1] & work_r[3]);
      k_val = K_0;
    end else if (round_r < 7'd40) begin
      f_val = work_r[1] ^ work_r[2] ^ work_r[3];
      k_val = K_1;
    end else if (round_r < 7'd60) begin
      f_val = (work_r[1] & work_r[2]) | (work_r[1] & work_r[3]) | (work_r[2] & work_r[3]);
      k_val = K_2;
    end else begin
      f_val = work_r[1] ^ work_r[2] ^ work_r[3];
      k_val = K_3;
    end
    round_sum = {work_r[0][26:0], work_r[0][31:27]} + f_val + work_r[4] + k_val + win_r[0];
    sched_x   = win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0];
    sched_new = {sched_x[30:0], sched_x[31]};
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.byte_present && (fill_r == LAST_FILL)) begin
            state_nxt = ST_ROUND;
          end else if (in_ch.end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (fill_r == LAST_FILL) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round_r == LAST_ROUND) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (final_r) begin
          state_nxt = ST_OUT;
        end else if (pad_active_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_load && (word_sel_r == LAST_IDX)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      round_r      <= '0;
      bit_count_r  <= '0;
      pad_active_r <= 1'b0;
      pad_first_r  <= 1'b0;
      extra_r      <= 1'b0;
      final_r      <= 1'b0;
      word_sel_r   <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NUM_CHAIN; i++) begin
        chain_r[i] <= H_INIT[i];
      end
    end else begin
      state_r <= state_nxt;

      if (byte_we) begin
        fill_r <= fill_r + 1'b1;
      end
      if ((state_r == ST_IDLE) && byte_we) begin
        bit_count_r <= bit_count_r + 64'd8;
      end
      if ((state_r == ST_IDLE) && in_fire && in_ch.end_of_message) begin
        pad_active_r <= 1'b1;
        pad_first_r  <= 1'b1;
      end
      if (state_r == ST_PAD) begin
        pad_first_r <= 1'b0;
        if (pad_first_r && (fill_r >= LEN_FILL)) begin
          extra_r <= 1'b1;
        end
        if (len_phase && (fill_r == LAST_FILL)) begin
          final_r <= 1'b1;
        end
      end

      if (state_r == ST_ROUND) begin
        round_r <= round_r + 1'b1;
      end else begin
        round_r <= '0;
      end

      if (state_r == ST_FOLD) begin
        for (int i = 0; i < NUM_CHAIN; i++) begin
          chain_r[i] <= chain_r[i] + work_r[i];
        end
        extra_r <= 1'b0;
        if (final_r) begin
          final_r      <= 1'b0;
          pad_active_r <= 1'b0;
          bit_count_r  <= '0;
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
        if (word_sel_r == LAST_IDX) begin
          word_sel_r <= '0;
          for (int i = 0; i < NUM_CHAIN; i++) begin
            chain_r[i] <= H_INIT[i];
          end
        end else begin
          word_sel_r <= word_sel_r + 1'b1;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath: byte packing, schedule window, working words, output word.
  always_ff @(posedge clk) begin
    if (byte_we) begin
      acc_r <= {acc_r[15:0], byte_val};
      if (fill_r[1:0] == 2'b11) begin
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
          win_r[i] <= win_r[i+1];
        end
        win_r[WIN_DEPTH-1] <= {acc_r, byte_val};
      end
    end else if (state_r == ST_ROUND) begin
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[WIN_DEPTH-1] <= sched_new;
    end

    if ((state_nxt == ST_ROUND) && (state_r != ST_ROUND)) begin
      for (int i = 0; i < NUM_CHAIN; i++) begin
        work_r[i] <= chain_r[i];
      end
    end else if (state_r == ST_ROUND) begin
      work_r[0] <= round_sum;
      work_r[1] <= work_r[0];
      work_r[2] <= {work_r[1][1:0], work_r[1][31:2]};
      work_r[3] <= work_r[2];
      work_r[4] <= work_r[3];
    end

    if (out_load) begin
      out_word_r <= chain_r[word_sel_r];
      out_idx_r  <= word_sel_r;
      out_last_r <= (word_sel_r == LAST_IDX);
    end
  end

  `SHA1_ASSERT_NOW(a_round_range, state_r == ST_ROUND, round_r <= LAST_ROUND, "round count past 79")
  `SHA1_ASSERT_NOW(a_block_full, state_r == ST_ROUND, fill_r == '0, "compression with partial block")
  `SHA1_ASSERT_NEXT(a_final_out, (state_r == ST_FOLD) && final_r, state_r == ST_OUT, "digest not emitted after final block")
  `SHA1_ASSERT_NOW(a_last_idx, out_valid_r && out_last_r, out_idx_r == LAST_IDX, "last word flag on wrong index")

endmodule

// ===== tb/sv/sha1_digest_checker.sv =====
// Digest checker for the SHA-1 engine: follows both channels, predicts digest words and compares.
`timescale 1ns / 1ps

module sha1_digest_checker import sha1_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sha1_in_if          in_ch,
  sha1_out_if         out_ch,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned words_checked
);

  typedef struct packed {
    logic [WORD_W-1:0] digest_word;
    logic [IDX_W-1:0]  word_index;
    logic              last_word;
  } digest_entry_t;

  // Predicted hash state
  logic [WORD_W-1:0] hash_h [NUM_CHAIN];
  logic [BYTE_W-1:0] msg_block [64];
  logic [FILL_W-1:0] block_fill;
  logic [LEN_W-1:0]  msg_bits;

  digest_entry_t digest_q [$];
  int unsigned   errors = 0;
  int unsigned   checked = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void restart_message();
    hash_h     = H_INIT;
    block_fill = '0;
    msg_bits   = '0;
  endfunction

  // Run 80 rounds over msg_block and fold the result into hash_h.
  function automatic void compress_block();
    logic [WORD_W-1:0] sched [WIN_DEPTH];
    logic [WORD_W-1:0] a, b, c, d, e, f, k, wt, sum;
    int r;
    a = hash_h[0];
    b = hash_h[1];
    c = hash_h[2];
    d = hash_h[3];
    e = hash_h[4];
    for (r = 0; r < 80; r++) begin
      if (r < 16) begin
        wt = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
      end else begin
        wt = sched[(r-3) & 15] ^ sched[(r-8) & 15] ^ sched[(r-14) & 15] ^ sched[r & 15];
        wt = {wt[30:0], wt[31]};
      end
      sched[r & 15] = wt;
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_2;
      end else begin
        f = b ^ c ^ d;
        k = K_3;
      end
      sum = {a[26:0], a[31:27]} + f + e + k + wt;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = sum;
    end
    hash_h[0] += a;
    hash_h[1] += b;
    hash_h[2] += c;
    hash_h[3] += d;
    hash_h[4] += e;
  endfunction

  // Take one accepted item; on the end mark pad, finish and queue the digest.
  function automatic void absorb_item(logic [BYTE_W-1:0] b, logic present, logic eom);
    int i;
    digest_entry_t ent;
    if (present) begin
      msg_block[block_fill] = b;
      block_fill++;
      msg_bits += LEN_W'(8);
      if (block_fill == '0) compress_block();
    end
    if (eom) begin
      msg_block[block_fill] = PAD_BYTE;
      for (i = int'(block_fill) + 1; i < 64; i++) msg_block[i] = '0;
      // no room for the length: spill into an extra block
      if (block_fill >= LEN_FILL) begin
        compress_block();
        for (i = 0; i < 64; i++) msg_block[i] = '0;
      end
      for (i = 0; i < 8; i++) msg_block[63-i] = msg_bits[8*i +: 8];
      compress_block();
      for (i = 0; i < NUM_CHAIN; i++) begin
        ent.digest_word = hash_h[i];
        ent.word_index  = IDX_W'(i);
        ent.last_word   = (IDX_W'(i) == LAST_IDX);
        digest_q.push_back(ent);
      end
      restart_message();
    end
  endfunction

  always @(posedge clk) begin
    digest_entry_t seen, want;
    if (!rst_n) begin
      restart_message();
      digest_q.delete();
    end else begin
      // retire outputs first: a digest never leaves in the cycle its end mark enters
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        seen.digest_word = out_ch.digest_word;
        seen.word_index  = out_ch.word_index;
        seen.last_word   = out_ch.last_word;
        if (digest_q.size() == 0) begin
          report_mismatch($sformatf("unexpected digest word %h at index %0d",
                                    seen.digest_word, seen.word_index));
        end else begin
          want = digest_q.pop_front();
          checked++;
          if (seen.digest_word !== want.digest_word)
            report_mismatch($sformatf("digest word %0d: got %h, expected %h",
                                      want.word_index, seen.digest_word, want.digest_word));
          if (seen.word_index !== want.word_index)
            report_mismatch($sformatf("word index: got %0d, expected %0d",
                                      seen.word_index, want.word_index));
          if (seen.last_word !== want.last_word)
            report_mismatch($sformatf("last word flag at index %0d: got %b, expected %b",
                                      want.word_index, seen.last_word, want.last_word));
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        absorb_item(in_ch.data_byte, in_ch.byte_present, in_ch.end_of_message);
    end
    pending       <= digest_q.size();
    fail_count    <= errors;
    words_checked <= checked;
  end

endmodule

// ===== tb/sv/sha1_hash_engine_tb.sv =====
// Testbench top for the SHA-1 engine: clock, reset, message stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module sha1_hash_engine_tb;
  import sha1_pkg::*;

  localparam int unsigned ITEM_TARGET = 410;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned TAIL_CYCLES = 400;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n;

  sha1_in_if  in_ch ();
  sha1_out_if out_ch ();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned words_checked;

  int unsigned items_sent = 0;
  int unsigned noop_count = 0;
  int unsigned cycle_count = 0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;

  sha1_hash_engine u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sha1_digest_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .words_checked (words_checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d digest words outstanding", cycle_count, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic send_item(input logic [BYTE_W-1:0] b, input logic present, input logic eom);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.data_byte      <= b;
    in_ch.byte_present   <= present;
    in_ch.end_of_message <= eom;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    items_sent++;
    if (!present && !eom) noop_count++;
  endtask

  // Drop valid and hold until every queued digest word has come out.
  task automatic drain_digests();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_message(input int unsigned len, input bit noisy);
    int unsigned n;
    bit mark_alone;
    mark_alone = (len == 0) || ($urandom_range(0, 1) == 1);
    for (n = 0; n < len; n++) begin
      if (noisy && $urandom_range(0, 9) == 0)
        send_item(pick_byte(), 1'b0, 1'b0);
      send_item(pick_byte(), 1'b1, (n == len - 1) && !mark_alone);
    end
    if (mark_alone) send_item(pick_byte(), 1'b0, 1'b1);
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        stall = idle_len();
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin : stimulus
    int unsigned msg_idx;
    int unsigned r;
    int unsigned len;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.data_byte      = '0;
    in_ch.byte_present   = 1'b0;
    in_ch.end_of_message = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: no-op at rest, empty messages, "abc", single bytes at the extremes, two bytes around a no-op
    send_item(8'h3C, 1'b0, 1'b0);
    send_item(8'hC3, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'h01, 1'b1, 1'b0);
    send_item(8'h7E, 1'b0, 1'b1);
    drain_digests();

    msg_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 5) == 0);
      case (msg_idx)
        4: begin
          // hold the output and keep offering messages so the engine backs up
          drain_digests();
          no_idle  = 1'b1;
          hold_req = 1'b1;
          repeat (4) send_message($urandom_range(1, 6), 1'b0);
          no_idle = 1'b0;
        end
        8:  send_message(55, 1'b1);
        14: send_message(56, 1'b1);
        20: send_message($urandom_range(57, 64), 1'b1);
        default: begin
          r = $urandom_range(0, 99);
          if (r < 10)      len = 0;
          else if (r < 75) len = $urandom_range(1, 8);
          else             len = $urandom_range(9, 30);
          send_message(len, 1'b1);
        end
      endcase
      if ($urandom_range(0, 7) == 0) drain_digests();
      msg_idx++;
    end
    no_idle = 1'b0;

    drain_digests();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d input items (%0d no-ops); checked %0d digest words of %0d messages.",
             items_sent, noop_count, words_checked, words_checked / 5);
    $display("Covered empty messages, end marks alone and on a byte, padding near a full block,",
             " a long output hold-off and drained pauses.");
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sha1_hash_engine.f =====
+incdir+hdl
hdl/sha1_pkg.sv
hdl/sha1_if.sv
hdl/sha1_hash_engine.sv
tb/sv/sha1_digest_checker.sv
tb/sv/sha1_hash_engine_tb.sv
